// File: rtl/lmbs_pkg.sv
// Shared types and constants for the LED mode blink sequencer.
`timescale 1ns / 1ps
package lmbs_pkg;

  localparam int PERIOD_WIDTH = 16;
  localparam int CFG_PERIOD_W = 16;
  localparam int CFG_COUNT_W  = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CMP_W        = (PERIOD_WIDTH > CFG_PERIOD_W) ? PERIOD_WIDTH : CFG_PERIOD_W;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_SET     = 3'd1,
    OP_SUCCESS = 3'd2,
    OP_ERROR   = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    MODE_NONE    = 3'd0,
    MODE_STEADY  = 3'd1,
    MODE_TARE    = 3'd2,
    MODE_CALZERO = 3'd3,
    MODE_CALMASS = 3'd4,
    MODE_SUCCESS = 3'd5,
    MODE_ERROR   = 3'd6
  } mode_t;

  localparam logic [2:0] MODE_INVALID = 3'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_PERIOD = 3'd0,
    REG_TARE_PERIOD   = 3'd1,
    REG_RESULT_PERIOD = 3'd2,
    REG_SUCCESS_COUNT = 3'd3,
    REG_ERROR_COUNT   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_PERIOD_W-1:0] normal_period;
    logic [CFG_PERIOD_W-1:0] tare_period;
    logic [CFG_PERIOD_W-1:0] result_period;
    logic [CFG_COUNT_W-1:0]  success_count;
    logic [CFG_COUNT_W-1:0]  error_count;
  } cfg_t;

  typedef struct packed {
    mode_t                   cur_mode;
    mode_t                   ret_mode;
    logic                    phase_on;
    logic [PERIOD_WIDTH-1:0] elapsed;
    logic [CFG_COUNT_W-1:0]  flashes_done;
    logic [CFG_COUNT_W-1:0]  flashes_target;
  } state_t;

  typedef struct packed {
    logic led_first;
    logic led_second;
    logic led_third;
    logic temporary_active;
  } leds_t;

endpackage

// File: rtl/lmbs_req_if.sv
// Request channel: operation and mode with valid/ready.
`timescale 1ns / 1ps
interface lmbs_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [2:0] mode;

  modport source (output valid, output operation, output mode, input ready);
  modport sink   (input valid, input operation, input mode, output ready);
endinterface

// File: rtl/lmbs_rsp_if.sv
// Result channel: LED levels and temporary flag with valid/ready.
`timescale 1ns / 1ps
interface lmbs_rsp_if;
  logic valid;
  logic ready;
  logic led_first;
  logic led_second;
  logic led_third;
  logic temporary_active;

  modport source (output valid, output led_first, output led_second, output led_third,
                  output temporary_active, input ready);
  modport sink   (input valid, input led_first, input led_second, input led_third,
                  input temporary_active, output ready);
endinterface

// File: rtl/lmbs_next.sv
// Next-state and LED decode for one request.
`timescale 1ns / 1ps
module lmbs_next import lmbs_pkg::*; (
  input  cfg_t       cfg,
  input  state_t     state,
  input  logic [2:0] operation,
  input  logic [2:0] mode,
  output state_t     state_next,
  output leds_t      leds_next
);

  localparam logic [PERIOD_WIDTH-1:0] ELAPSED_MAX = {PERIOD_WIDTH{1'b1}};

  mode_t                   req_mode;
  logic                    is_temp;
  logic                    is_blink;
  logic [CFG_PERIOD_W-1:0] period;
  logic [PERIOD_WIDTH-1:0] elapsed_inc;
  logic [CFG_COUNT_W-1:0]  done_inc;
  logic                    ph;

  assign req_mode = (mode == MODE_INVALID) ? MODE_NONE : mode_t'(mode);
  assign is_temp  = (state.cur_mode == MODE_SUCCESS) || (state.cur_mode == MODE_ERROR);
  assign is_blink = is_temp || (state.cur_mode == MODE_TARE) ||
                    (state.cur_mode == MODE_CALZERO) || (state.cur_mode == MODE_CALMASS);
  assign elapsed_inc = (state.elapsed != ELAPSED_MAX) ? state.elapsed + 1'b1 : state.elapsed;
  assign done_inc    = state.flashes_done + 1'b1;

  always_comb begin
    if (state.cur_mode == MODE_TARE) begin
      period = cfg.tare_period;
    end else if (is_temp) begin
      period = cfg.result_period;
    end else begin
      period = cfg.normal_period;
    end
  end

  always_comb begin
    state_next = state;
    case (operation)
      OP_TICK: begin
        state_next.elapsed = elapsed_inc;
        if (is_blink && (CMP_W'(elapsed_inc) >= CMP_W'(period))) begin
          state_next.elapsed  = '0;
          state_next.phase_on = ~state.phase_on;
          if (is_temp && state.phase_on) begin
            state_next.flashes_done = done_inc;
            if (done_inc >= state.flashes_target) begin
              state_next.cur_mode       = state.ret_mode;
              state_next.ret_mode       = MODE_NONE;
              state_next.flashes_done   = '0;
              state_next.flashes_target = '0;
              state_next.phase_on       = 1'b1;
            end
          end
        end
      end
      OP_SET: begin
        state_next.cur_mode       = req_mode;
        state_next.ret_mode       = MODE_NONE;
        state_next.flashes_done   = '0;
        state_next.flashes_target = '0;
        state_next.phase_on       = 1'b1;
        state_next.elapsed        = '0;
      end
      OP_SUCCESS: begin
        state_next.cur_mode       = MODE_SUCCESS;
        state_next.ret_mode       = MODE_NONE;
        state_next.flashes_done   = '0;
        state_next.flashes_target = cfg.success_count;
        state_next.phase_on       = 1'b1;
        state_next.elapsed        = '0;
      end
      OP_ERROR: begin
        state_next.cur_mode       = MODE_ERROR;
        state_next.ret_mode       = req_mode;
        state_next.flashes_done   = '0;
        state_next.flashes_target = cfg.error_count;
        state_next.phase_on       = 1'b1;
        state_next.elapsed        = '0;
      end
      OP_CLEAR: begin
        state_next.cur_mode       = MODE_NONE;
        state_next.ret_mode       = MODE_NONE;
        state_next.phase_on       = 1'b0;
        state_next.flashes_done   = '0;
        state_next.flashes_target = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    ph = state_next.phase_on;
    leds_next = '0;
    unique case (state_next.cur_mode)
      MODE_STEADY:  leds_next = '{1'b1, 1'b1, 1'b1, 1'b0};
      MODE_TARE:    leds_next = '{ph, ph, ph, 1'b0};
      MODE_CALZERO: leds_next = '{ph, 1'b0, 1'b0, 1'b0};
      MODE_CALMASS: leds_next = '{1'b0, ph, 1'b0, 1'b0};
      MODE_SUCCESS: leds_next = '{ph, ph, ph, 1'b1};
      MODE_ERROR:   leds_next = '{1'b0, 1'b0, ph, 1'b1};
      default:      leds_next = '0;
    endcase
  end

endmodule

// File: rtl/led_mode_blink_sequencer_top.sv
// Top level of the LED mode blink sequencer.
// Takes one request per cycle while results are taken (a millisecond tick or a mode
// command) and returns one result per request: the three LED levels and the temporary
// flag as they stand after that request. Each request passes through a single next-state
// stage into a result register; the request side stays ready whenever the result register
// is empty or being drained, so requests and results stream at one per cycle. Configuration
// writes take effect on the next cycle and belong between requests while the block is idle.
`timescale 1ns / 1ps
module led_mode_blink_sequencer_top import lmbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lmbs_req_if.sink              req,
  lmbs_rsp_if.source            rsp
);

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  leds_t  leds_next;
  leds_t  leds;
  logic   rsp_valid;
  logic   accept;

  assign req.ready = ~rsp_valid | rsp.ready;
  assign accept    = req.valid & req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_period <= CFG_PERIOD_W'(500);
      cfg.tare_period   <= CFG_PERIOD_W'(250);
      cfg.result_period <= CFG_PERIOD_W'(150);
      cfg.success_count <= CFG_COUNT_W'(3);
      cfg.error_count   <= CFG_COUNT_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NORMAL_PERIOD: cfg.normal_period <= cfg_data[CFG_PERIOD_W-1:0];
        REG_TARE_PERIOD:   cfg.tare_period   <= cfg_data[CFG_PERIOD_W-1:0];
        REG_RESULT_PERIOD: cfg.result_period <= cfg_data[CFG_PERIOD_W-1:0];
        REG_SUCCESS_COUNT: cfg.success_count <= cfg_data[CFG_COUNT_W-1:0];
        REG_ERROR_COUNT:   cfg.error_count   <= cfg_data[CFG_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  lmbs_next u_next (
    .cfg        (cfg),
    .state      (state),
    .operation  (req.operation),
    .mode       (req.mode),
    .state_next (state_next),
    .leds_next  (leds_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        state     <= state_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (accept) begin
      leds <= leds_next;
    end
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.led_first        = leds.led_first;
  assign rsp.led_second       = leds.led_second;
  assign rsp.led_third        = leds.led_third;
  assign rsp.temporary_active = leds.temporary_active;

endmodule

// File: rtl/lmbs_chk.sv
// Port-level checks for the LED mode blink sequencer, bound to the top level.
`timescale 1ns / 1ps
module lmbs_chk (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic led_first,
  input logic led_second,
  input logic led_third,
  input logic temporary_active
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_req_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("accepted request gave no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request side stalled with empty result register");

  a_temp_pattern: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && temporary_active |-> led_first == led_second)
    else $error("temporary pattern shows mismatched first and second LEDs");

  a_calzero_pattern: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && led_first && !led_second |-> !led_third && !temporary_active)
    else $error("impossible LED combination");

endmodule

bind led_mode_blink_sequencer_top lmbs_chk u_lmbs_chk (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .led_first        (rsp.led_first),
  .led_second       (rsp.led_second),
  .led_third        (rsp.led_third),
  .temporary_active (rsp.temporary_active)
);
